@@ sv/hsd_pkg.sv @@
// Shared types, constants and jamo lookup functions for the Hangul syllable decomposer.
// Used by hsd_split, hsd_queue, hsd_emit and hangul_syllable_decomposer.
package hsd_pkg;

   localparam int CP_W     = 21;  // code point width
   localparam int TDATA_W  = 24;  // code point padded to whole bytes
   localparam int IDX_W    = 14;  // syllable index, 0..11171
   localparam int Q_W      = 9;   // index / 28, 0..398
   localparam int INI_W    = 5;   // initial index, 0..18
   localparam int MED_W    = 5;   // medial index, 0..20
   localparam int FIN_W    = 5;   // final index, 0..27

   localparam logic [CP_W-1:0] SYL_FIRST   = 21'h00AC00;
   localparam logic [CP_W-1:0] SYL_LAST    = 21'h00D7A3;
   localparam logic [CP_W-1:0] MEDIAL_BASE = 21'h00314F;

   // floor(x / 28) = (x * 9363) >> 18 for x below 11172
   localparam logic [IDX_W-1:0] DIV28_MULT  = 14'd9363;
   localparam int               DIV28_SHIFT = 18;
   // floor(x / 21) = (x * 781) >> 14 for x below 399
   localparam logic [9:0]       DIV21_MULT  = 10'd781;
   localparam int               DIV21_SHIFT = 14;

   localparam int QUEUE_DEPTH_DEF = 8;

   typedef struct packed {
      logic [CP_W-1:0]  cp;    // original code point
      logic             syl;   // precomposed syllable
      logic [INI_W-1:0] ini;
      logic [Q_W-1:0]   q28;   // syllable index / 28
      logic [FIN_W-1:0] fin;
   } hsd_rec_type;

   function automatic logic [CP_W-1:0] initial_jamo(input logic [INI_W-1:0] ini);
      logic [CP_W-1:0] jamo;
      case (ini)
         5'd0:    jamo = 21'h3131;
         5'd1:    jamo = 21'h3132;
         5'd2:    jamo = 21'h3134;
         5'd3:    jamo = 21'h3137;
         5'd4:    jamo = 21'h3138;
         5'd5:    jamo = 21'h3139;
         5'd6:    jamo = 21'h3141;
         5'd7:    jamo = 21'h3142;
         5'd8:    jamo = 21'h3143;
         5'd9:    jamo = 21'h3145;
         5'd10:   jamo = 21'h3146;
         5'd11:   jamo = 21'h3147;
         5'd12:   jamo = 21'h3148;
         5'd13:   jamo = 21'h3149;
         5'd14:   jamo = 21'h314A;
         5'd15:   jamo = 21'h314B;
         5'd16:   jamo = 21'h314C;
         5'd17:   jamo = 21'h314D;
         default: jamo = 21'h314E;
      endcase
      return jamo;
   endfunction

   function automatic logic [CP_W-1:0] final_jamo(input logic [FIN_W-1:0] fin);
      logic [CP_W-1:0] jamo;
      case (fin)
         5'd1:    jamo = 21'h3131;
         5'd2:    jamo = 21'h3132;
         5'd3:    jamo = 21'h3133;
         5'd4:    jamo = 21'h3134;
         5'd5:    jamo = 21'h3135;
         5'd6:    jamo = 21'h3136;
         5'd7:    jamo = 21'h3137;
         5'd8:    jamo = 21'h3139;
         5'd9:    jamo = 21'h313A;
         5'd10:   jamo = 21'h313B;
         5'd11:   jamo = 21'h313C;
         5'd12:   jamo = 21'h313D;
         5'd13:   jamo = 21'h313E;
         5'd14:   jamo = 21'h313F;
         5'd15:   jamo = 21'h3140;
         5'd16:   jamo = 21'h3141;
         5'd17:   jamo = 21'h3142;
         5'd18:   jamo = 21'h3144;
         5'd19:   jamo = 21'h3145;
         5'd20:   jamo = 21'h3146;
         5'd21:   jamo = 21'h3147;
         5'd22:   jamo = 21'h3148;
         5'd23:   jamo = 21'h314A;
         5'd24:   jamo = 21'h314B;
         5'd25:   jamo = 21'h314C;
         5'd26:   jamo = 21'h314D;
         5'd27:   jamo = 21'h314E;
         default: jamo = '0;
      endcase
      return jamo;
   endfunction

endpackage

@@ sv/hsd_split.sv @@
// Two-stage input pipeline: range test, division by 28 and by 21 through reciprocals.
// Produces one queue record per accepted beat. Depends on hsd_pkg.
module hsd_split import hsd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [CP_W-1:0]                      req_cp,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     fill,
   output logic                                 wr_en,
   output hsd_rec_type                          wr_rec
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic             a_valid_ff, a_valid_in;
   logic [CP_W-1:0]  a_cp_ff;
   logic             a_syl_ff, a_syl_in;
   logic [IDX_W-1:0] a_idx_ff, a_idx_in;

   logic             b_valid_ff;
   logic [CP_W-1:0]  b_cp_ff;
   logic             b_syl_ff;
   logic [IDX_W-1:0] b_idx_ff;
   logic [Q_W-1:0]   b_q_ff, b_q_in;

   logic [CW:0]           inflight;
   logic [CP_W-1:0]       cp_diff;
   logic [2*IDX_W-1:0]    a_prod;
   logic [Q_W+9:0]        ini_prod;
   logic [IDX_W-1:0]      q_x28;
   logic [IDX_W-1:0]      fin_diff;

   // reserve a queue slot for every item still in the pipeline
   assign inflight   = {1'b0, fill} + (CW+1)'(a_valid_ff) + (CW+1)'(b_valid_ff);
   assign req_tready = inflight < (CW+1)'(QUEUE_DEPTH);
   assign a_valid_in = req_tvalid & req_tready;

   assign cp_diff  = req_cp - SYL_FIRST;
   assign a_syl_in = (req_cp >= SYL_FIRST) && (req_cp <= SYL_LAST);
   assign a_idx_in = cp_diff[IDX_W-1:0];

   assign a_prod = (2*IDX_W)'(a_idx_ff) * (2*IDX_W)'(DIV28_MULT);
   assign b_q_in = a_prod[DIV28_SHIFT +: Q_W];

   assign ini_prod = (Q_W+10)'(b_q_ff) * (Q_W+10)'(DIV21_MULT);
   assign q_x28    = (IDX_W'(b_q_ff) << 5) - (IDX_W'(b_q_ff) << 2);
   assign fin_diff = b_idx_ff - q_x28;

   assign wr_en      = b_valid_ff;
   assign wr_rec.cp  = b_cp_ff;
   assign wr_rec.syl = b_syl_ff;
   assign wr_rec.ini = ini_prod[DIV21_SHIFT +: INI_W];
   assign wr_rec.q28 = b_q_ff;
   assign wr_rec.fin = fin_diff[FIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_cp_ff  <= req_cp;
      a_syl_ff <= a_syl_in;
      a_idx_ff <= a_idx_in;
      b_cp_ff  <= a_cp_ff;
      b_syl_ff <= a_syl_ff;
      b_idx_ff <= a_idx_ff;
      b_q_ff   <= b_q_in;
   end

endmodule

@@ sv/hsd_queue.sv @@
// Record queue: one synchronous memory with a registered read port that acts as the head slot.
// Reads only committed entries, so a write and a read never meet on one entry. Depends on hsd_pkg.
module hsd_queue import hsd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  hsd_rec_type                          wr_rec,
   input  logic                                 pop,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     fill,
   output logic                                 head_valid,
   output hsd_rec_type                          head_rec
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   hsd_rec_type     queue_mem_ff [QUEUE_DEPTH];
   hsd_rec_type     rd_data_ff;
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            head_valid_ff, head_valid_in;
   logic            rd_en;

   // refill the head when it is empty, or in the same cycle its last beat is loaded for output
   assign rd_en         = (fill_ff != '0) && (!head_valid_ff || pop);
   assign head_valid_in = rd_en || (head_valid_ff && !pop);
   assign fill_in       = fill_ff + CW'(wr_en) - CW'(rd_en);
   assign wr_ptr_in     = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in     = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         fill_ff       <= fill_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem_ff[wr_ptr_ff] <= wr_rec;
      end
      if (rd_en) begin
         rd_data_ff <= queue_mem_ff[rd_ptr_ff];
      end
   end

   assign fill       = fill_ff;
   assign head_valid = head_valid_ff;
   assign head_rec   = rd_data_ff;

endmodule

@@ sv/hsd_emit.sv @@
// Beat sequencer: turns the head record into one to three result beats in an output register.
// Depends on hsd_pkg.
module hsd_emit import hsd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              mode,
   input  logic              head_valid,
   input  hsd_rec_type       head_rec,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CP_W-1:0]   rsp_cp,
   output logic              rsp_tlast
);

   typedef enum logic [1:0] {
      BEAT_INI,
      BEAT_MED,
      BEAT_FIN
   } beat_type;

   beat_type          beat_ff, beat_in;
   logic              rsp_tvalid_ff;
   logic [CP_W-1:0]   rsp_cp_ff, rsp_cp_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              load;
   logic [Q_W-1:0]    ini_x21;
   logic [Q_W-1:0]    med_diff;
   logic [MED_W-1:0]  med;

   assign load = head_valid && (!rsp_tvalid_ff || rsp_tready);
   assign pop  = load && rsp_last_in;

   assign ini_x21  = (Q_W'(head_rec.ini) << 4) + (Q_W'(head_rec.ini) << 2)
                     + Q_W'(head_rec.ini);
   assign med_diff = head_rec.q28 - ini_x21;
   assign med      = med_diff[MED_W-1:0];

   always_comb begin
      case (beat_ff)
         BEAT_INI: begin
            rsp_cp_in   = head_rec.syl ? initial_jamo(head_rec.ini) : head_rec.cp;
            rsp_last_in = !head_rec.syl || mode;
         end
         BEAT_MED: begin
            rsp_cp_in   = MEDIAL_BASE + CP_W'(med);
            rsp_last_in = (head_rec.fin == '0);
         end
         BEAT_FIN: begin
            rsp_cp_in   = final_jamo(head_rec.fin);
            rsp_last_in = 1'b1;
         end
         default: begin
            rsp_cp_in   = head_rec.cp;
            rsp_last_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      beat_in = beat_ff;
      if (pop) begin
         beat_in = BEAT_INI;
      end else if (load) begin
         case (beat_ff)
            BEAT_INI: beat_in = BEAT_MED;
            BEAT_MED: beat_in = BEAT_FIN;
            default:  beat_in = BEAT_INI;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff       <= BEAT_INI;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         beat_ff <= beat_in;
         if (load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_cp_ff     <= rsp_cp_in;
            rsp_last_ff   <= rsp_last_in;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_cp     = rsp_cp_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/hangul_syllable_decomposer.sv @@
// Hangul syllable decomposer, top level.
// req_* takes one code point per beat. A precomposed syllable (U+AC00..U+D7A3)
// leaves on rsp_* as its initial, medial and, if present, final compatibility
// jamo; with the mode register set, as its initial alone. Any other code point
// passes through as one beat. rsp_tlast marks the last beat of each input.
// csr_* writes the mode register (bit 0: initial only); write it only while idle.
// Items pass the two split stages, the queue memory, the head slot and the single
// output register, which sets the throughput: one rsp beat per cycle while
// rsp_tready is high, so an item takes one to three beats (three with a final).
// Accepted items wait as records in a QUEUE_DEPTH-entry queue memory; req_tready
// drops once the queue plus the two split stages hold QUEUE_DEPTH items.
// When rsp_tready is low the output beat holds, the queue fills, then req stalls.
// Reset clears the pipeline, the queue pointers and the mode register (full mode).
// No clearing pass is needed: queue entries are read only after being written.
module hangul_syllable_decomposer import hsd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // [20:0] code_point_in, [23:21] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,   // [20:0] code_point_out, [23:21] zero
   output logic                 rsp_tlast,   // last_of_run
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data     // initial_only_mode
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic            mode_ff;
   logic            wr_en;
   hsd_rec_type     wr_rec;
   logic [CW-1:0]   fill;
   logic            head_valid;
   hsd_rec_type     head_rec;
   logic            pop;
   logic [CP_W-1:0] rsp_cp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   hsd_split #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_split (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cp     (req_tdata[CP_W-1:0]),
      .fill       (fill),
      .wr_en      (wr_en),
      .wr_rec     (wr_rec)
   );

   hsd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_rec     (wr_rec),
      .pop        (pop),
      .fill       (fill),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   hsd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_cp     (rsp_cp),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {(TDATA_W - CP_W)'(0), rsp_cp};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= CW'(QUEUE_DEPTH))
      else $error("queue fill exceeds depth");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> fill < CW'(QUEUE_DEPTH))
      else $error("input taken with a full queue");

   a_head_refill: assert property (@(posedge clock) disable iff (reset)
      (fill != '0 && !head_valid) |=> head_valid)
      else $error("head slot not refilled from a nonempty queue");

   a_pop_only_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && (rsp_tready || !rsp_tvalid))
      else $error("record released without its last beat loaded");

endmodule
